[design/assert_macros.svh]
// Assertion macros used by the checker module of the design.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[design/fde_pkg.sv]
// Shared types and constants of the FAT directory entry decoder.
// Used by every module of the block; depends on nothing.
package fde_pkg;

    // Entry geometry
    localparam int ENTRY_LEN = 32;
    localparam int POS_W     = $clog2(ENTRY_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(ENTRY_LEN - 1);

    // Marker bytes
    localparam logic [7:0] LEAD_END       = 8'h00;
    localparam logic [7:0] LEAD_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0] ATTR_DIR_MASK  = 8'h10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_REGION_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SECTORS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES      = 2'd3;
    localparam int CFG_DATA_W = 48;

    // Arithmetic widths
    localparam int SECTOR_W = 48;
    localparam int BPC_W    = 24;   // 8 x 16 bit bytes per cluster
    localparam int PROD_W   = 40;   // 32 x 8 bit cluster offset in sectors
    localparam int DIV_STEPS = 16;  // two quotient bits per step
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output stream width, padded to whole bytes
    localparam int RESULT_BITS = 3 + 64 + 24 + 8 + 32 + 32 + 32 + 48;
    localparam int OUT_DATA_W  = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        KIND_FILE      = 3'd0,
        KIND_DIR       = 3'd1,
        KIND_DELETED   = 3'd2,
        KIND_LONG_NAME = 3'd3,
        KIND_END       = 3'd4
    } entry_kind_t;

    // One classified entry, front to back
    typedef struct packed {
        entry_kind_t  kind;
        logic [63:0]  base_name;
        logic [23:0]  extension;
        logic [7:0]   attributes;
        logic [31:0]  first_cluster;
        logic [31:0]  file_size;
    } job_t;

    // One finished result
    typedef struct packed {
        logic [SECTOR_W-1:0] first_sector;
        logic [31:0]         cluster_count;
        logic [31:0]         file_size;
        logic [31:0]         first_cluster;
        logic [7:0]          attributes;
        logic [23:0]         extension;
        logic [63:0]         base_name;
        entry_kind_t         entry_kind;
    } result_t;

    // Configuration registers as seen by the back end
    typedef struct packed {
        logic [SECTOR_W-1:0] partition_start;
        logic [SECTOR_W-1:0] data_region_start;
        logic [7:0]          cluster_sectors;
        logic [15:0]         sector_bytes;
    } cfg_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic not_empty;
    } qstat_t;

endpackage

[design/fde_front.sv]
// Front end: gathers bytes into 32-byte entries and classifies them.
// Depends on fde_pkg.
module fde_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  fde_pkg::qstat_t q_stat,
    output logic          push,
    output fde_pkg::job_t push_job
);

    logic [fde_pkg::POS_W-1:0] pos_reg;
    logic [fde_pkg::POS_W-1:0] pos_next;
    logic                      skip_reg;
    logic                      skip_next;
    logic [7:0]                entry_reg [fde_pkg::ENTRY_LEN];
    logic                      accept;
    logic                      at_last;
    fde_pkg::entry_kind_t      kind;

    // Stall only when an entry completes into a full queue
    assign at_last  = (pos_reg == fde_pkg::LAST_POS);
    assign in_ready = skip_reg || !at_last || !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && !skip_reg && at_last;

    // Classification of the entry that completes with this byte
    always_comb
    begin
        if (entry_reg[0] == fde_pkg::LEAD_END)
            kind = fde_pkg::KIND_END;
        else if (entry_reg[0] == fde_pkg::LEAD_DELETED)
            kind = fde_pkg::KIND_DELETED;
        else if (entry_reg[11] == fde_pkg::ATTR_LONG_NAME)
            kind = fde_pkg::KIND_LONG_NAME;
        else if ((entry_reg[11] & fde_pkg::ATTR_DIR_MASK) != 8'h00)
            kind = fde_pkg::KIND_DIR;
        else
            kind = fde_pkg::KIND_FILE;
    end

    // Job fields; the last size byte is the one arriving now
    always_comb
    begin
        push_job.kind          = kind;
        push_job.base_name     = {entry_reg[7], entry_reg[6], entry_reg[5], entry_reg[4],
                                  entry_reg[3], entry_reg[2], entry_reg[1], entry_reg[0]};
        push_job.extension     = {entry_reg[10], entry_reg[9], entry_reg[8]};
        push_job.attributes    = entry_reg[11];
        push_job.first_cluster = {entry_reg[21], entry_reg[20], entry_reg[27], entry_reg[26]};
        push_job.file_size     = {in_byte, entry_reg[30], entry_reg[29], entry_reg[28]};
    end

    // Position and skip tracking
    always_comb
    begin
        pos_next  = pos_reg;
        skip_next = skip_reg;
        if (accept)
        begin
            if (skip_reg)
            begin
                if (in_last)
                begin
                    skip_next = 1'b0;
                    pos_next  = '0;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;   // wraps to 0 after the last byte
                if (at_last && kind == fde_pkg::KIND_END && !in_last)
                    skip_next = 1'b1;
                if (in_last)
                    pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    // Entry byte store, no reset: every byte is written before use
    always_ff @(posedge clk)
    begin
        if (accept && !skip_reg)
            entry_reg[pos_reg] <= in_byte;
    end

endmodule

[design/fde_queue.sv]
// Short job queue decoupling the front end from the back end.
// Depends on fde_pkg.
module fde_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fde_pkg::job_t   push_job,
    input  logic            pop,
    output fde_pkg::job_t   head_job,
    output fde_pkg::qstat_t stat
);

    fde_pkg::job_t              mem_reg [fde_pkg::QUEUE_DEPTH];
    logic [fde_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fde_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fde_pkg::QCNT_W-1:0] count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign stat.full      = (count_reg == fde_pkg::QCNT_W'(fde_pkg::QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign do_push        = push && !stat.full;
    assign do_pop         = pop && stat.not_empty;
    assign head_job       = mem_reg[rd_ptr_reg];

    function automatic logic [fde_pkg::QPTR_W-1:0] ptr_inc(
        input logic [fde_pkg::QPTR_W-1:0] p
    );
        if (p == fde_pkg::QPTR_W'(fde_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[design/fde_back.sv]
// Back end: cluster count by iterative division, first sector, output register.
// Depends on fde_pkg.
module fde_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fde_pkg::cfg_t   cfg,
    input  fde_pkg::qstat_t q_stat,
    input  fde_pkg::job_t   head_job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output fde_pkg::result_t out_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                        state_reg;
    fde_pkg::job_t                 job_reg;
    logic [fde_pkg::BPC_W-1:0]     bpc_reg;
    logic [fde_pkg::PROD_W-1:0]    prod_reg;
    logic [fde_pkg::SECTOR_W-1:0]  base_reg;
    logic [31:0]                   quo_reg;
    logic [31:0]                   quo_next;
    logic [fde_pkg::BPC_W-1:0]     rem_reg;
    logic [fde_pkg::BPC_W-1:0]     rem_next;
    logic [fde_pkg::DIV_CNT_W-1:0] step_reg;
    logic                          out_valid_reg;
    fde_pkg::result_t              result_reg;

    logic [fde_pkg::BPC_W:0]       r1;
    logic [fde_pkg::BPC_W:0]       r1s;
    logic [fde_pkg::BPC_W:0]       r2;
    logic [fde_pkg::BPC_W:0]       r2s;
    logic                          ge1;
    logic                          ge2;
    logic                          needs_div;
    logic                          is_entry;
    logic                          out_free;
    logic [31:0]                   rel;
    logic [31:0]                   count;

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign pop        = (state_reg == ST_IDLE) && q_stat.not_empty;

    assign needs_div = (job_reg.kind == fde_pkg::KIND_FILE) && (job_reg.file_size != '0);
    assign is_entry  = (job_reg.kind == fde_pkg::KIND_FILE) ||
                       (job_reg.kind == fde_pkg::KIND_DIR);
    assign rel       = job_reg.first_cluster - 32'd2;

    // Two restoring division steps per cycle
    always_comb
    begin
        r1  = {rem_reg, quo_reg[31]};
        ge1 = (r1 >= {1'b0, bpc_reg});
        r1s = ge1 ? (r1 - {1'b0, bpc_reg}) : r1;
        r2  = {r1s[fde_pkg::BPC_W-1:0], quo_reg[30]};
        ge2 = (r2 >= {1'b0, bpc_reg});
        r2s = ge2 ? (r2 - {1'b0, bpc_reg}) : r2;
        quo_next = {quo_reg[29:0], ge1, ge2};
        rem_next = r2s[fde_pkg::BPC_W-1:0];
    end

    // Ceiling of the quotient; zero when no division is needed, all ones for a zero divisor
    always_comb
    begin
        if (!needs_div)
            count = '0;
        else if (bpc_reg == '0)
            count = '1;
        else
            count = quo_reg + {31'd0, (rem_reg != '0)};
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            // In the finishing state the output is either reloaded or still held
            if (out_valid_reg && out_ready && state_reg != ST_FIN)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        job_reg   <= head_job;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    bpc_reg   <= fde_pkg::BPC_W'(cfg.sector_bytes) *
                                 fde_pkg::BPC_W'(cfg.cluster_sectors);
                    prod_reg  <= fde_pkg::PROD_W'(rel) *
                                 fde_pkg::PROD_W'(cfg.cluster_sectors);
                    base_reg  <= cfg.partition_start + cfg.data_region_start;
                    quo_reg   <= job_reg.file_size;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= needs_div ? ST_DIV : ST_FIN;
                end
                ST_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == fde_pkg::DIV_CNT_W'(fde_pkg::DIV_STEPS - 1))
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        result_reg.entry_kind    <= job_reg.kind;
                        result_reg.base_name     <= is_entry ? job_reg.base_name : '0;
                        result_reg.extension     <= is_entry ? job_reg.extension : '0;
                        result_reg.attributes    <= is_entry ? job_reg.attributes : '0;
                        result_reg.first_cluster <= is_entry ? job_reg.first_cluster : '0;
                        result_reg.file_size     <= is_entry ? job_reg.file_size : '0;
                        result_reg.cluster_count <= count;
                        result_reg.first_sector  <= is_entry ?
                            (base_reg + {{(fde_pkg::SECTOR_W - fde_pkg::PROD_W){1'b0}},
                                         prod_reg}) : '0;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/fat_directory_entry_decoder.sv]
// Results: a non-empty file entry passes through the back end's 16-step divider;
// other kinds and empty files go from the multiply state straight to the finish.
// Throughput: one byte per cycle, held off only when an entry completes into a
// full queue; a two-entry queue between front and back absorbs output stalls.
// Reset: asynchronous, active low; clears position, queue, sequencer and
// output valid, and loads the configuration defaults (1 sector, 512 bytes).
module fat_directory_entry_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tlast,  // cluster_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] entry_kind, [66:3] base_name, [90:67] extension,
    // [98:91] attributes, [130:99] first_cluster, [162:131] file_size,
    // [194:163] cluster_count, [242:195] first_sector, rest zero
    output logic [fde_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fde_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    fde_pkg::cfg_t    cfg_reg;
    fde_pkg::qstat_t  q_stat;
    fde_pkg::job_t    push_job;
    fde_pkg::job_t    head_job;
    fde_pkg::result_t result;
    logic             push;
    logic             pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.partition_start   <= '0;
            cfg_reg.data_region_start <= '0;
            cfg_reg.cluster_sectors   <= 8'd1;
            cfg_reg.sector_bytes      <= 16'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fde_pkg::CFG_PARTITION_START:
                    cfg_reg.partition_start <= cfg_wdata[fde_pkg::SECTOR_W-1:0];
                fde_pkg::CFG_DATA_REGION_START:
                    cfg_reg.data_region_start <= cfg_wdata[fde_pkg::SECTOR_W-1:0];
                fde_pkg::CFG_CLUSTER_SECTORS:
                    cfg_reg.cluster_sectors <= cfg_wdata[7:0];
                fde_pkg::CFG_SECTOR_BYTES:
                    cfg_reg.sector_bytes <= cfg_wdata[15:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    fde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    fde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    fde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result, kind in the lowest bits
    assign m_axis_tdata = {{(fde_pkg::OUT_DATA_W - fde_pkg::RESULT_BITS){1'b0}}, result};

endmodule

[design/fde_checker.sv]
// Port-level checks of the FAT directory entry decoder, bound to the top level.
// Depends on fde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fde_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [fde_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [2:0] kind;
    logic       nondata;

    assign kind    = m_axis_tdata[2:0];
    assign nondata = (kind == fde_pkg::KIND_DELETED) || (kind == fde_pkg::KIND_LONG_NAME) ||
                     (kind == fde_pkg::KIND_END);

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Marker kinds carry nothing but the kind
    `ASSERT_IMPLY(a_marker_zero, clk, rst_n, m_axis_tvalid && nondata,
                  m_axis_tdata[fde_pkg::RESULT_BITS-1:3] == '0)

    // Directories never need a cluster count and have the directory bit set
    `ASSERT_IMPLY(a_dir_count, clk, rst_n, m_axis_tvalid && kind == fde_pkg::KIND_DIR,
                  m_axis_tdata[194:163] == 32'd0 && m_axis_tdata[95] == 1'b1)

    // Files have the directory bit clear; an empty file needs no clusters
    `ASSERT_IMPLY(a_file_attr, clk, rst_n, m_axis_tvalid && kind == fde_pkg::KIND_FILE,
                  m_axis_tdata[95] == 1'b0 &&
                  (m_axis_tdata[162:131] != 32'd0 || m_axis_tdata[194:163] == 32'd0))

endmodule

bind fat_directory_entry_decoder fde_checker u_fde_checker (.*);

[verif/fat_directory_entry_decoder_test.sv]
// Self-checking testbench for the FAT directory entry decoder.
// Streams directory clusters into the block and checks every decoded entry.
// Depends on fde_pkg and fat_directory_entry_decoder only.
module fat_directory_entry_decoder_test;
    import fde_pkg::*;

    localparam int SETTLE_CYCLES   = 40;    // lets the back end finish its last entries
    localparam int HOLD_OFF_CYCLES = 400;   // long output stall, fills the two-entry queue
    localparam int STALL_LIMIT     = 3000;  // cycles with no item moving on either side
    localparam int REPORT_LIMIT    = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    // Clock, reset and block ports
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;  // [7:0] data_byte
    logic                  s_axis_tlast  = 1'b0; // cluster_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] entry_kind, [66:3] base_name, [90:67] extension, [98:91] attributes,
    // [130:99] first_cluster, [162:131] file_size, [194:163] cluster_count,
    // [242:195] first_sector, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Stimulus and expectations
    stream_byte_t pending_bytes[$];
    result_t      decoded_entries[$];

    // Decoder copy: registers and entry gathering state
    logic [47:0] cfg_part_start = '0;
    logic [47:0] cfg_data_start = '0;
    logic [7:0]  cfg_spc        = 8'd1;
    logic [15:0] cfg_bps        = 16'd512;
    logic [4:0]  model_pos      = '0;
    logic [7:0]  model_entry [ENTRY_LEN];
    logic        model_skip     = 1'b0;

    // Handshake pacing
    int   idle_pct    = 0;
    int   tx_gap      = 0;
    int   rx_gap      = 0;
    int   hold_left   = 0;
    bit   hold_req    = 1'b0;
    bit   byte_taken  = 1'b0;
    logic next_valid;
    logic next_ready;
    stream_byte_t sent;

    // Bookkeeping
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int entries_seen  = 0;
    int bytes_queued  = 0;
    int kind_seen [5] = '{0, 0, 0, 0, 0};

    fat_directory_entry_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decode the gathered 32 bytes the way the block should
    function automatic result_t decode_entry();
        result_t     r;
        logic [31:0] clus;
        logic [31:0] size;
        logic [31:0] rel;
        logic [23:0] bpc;
        logic [63:0] count;
        int          i;
        r = '0;
        if (model_entry[0] == LEAD_END)
            r.entry_kind = KIND_END;
        else if (model_entry[0] == LEAD_DELETED)
            r.entry_kind = KIND_DELETED;
        else if (model_entry[11] == ATTR_LONG_NAME)
            r.entry_kind = KIND_LONG_NAME;
        else
        begin
            if ((model_entry[11] & ATTR_DIR_MASK) != 8'h00)
                r.entry_kind = KIND_DIR;
            else
                r.entry_kind = KIND_FILE;
            for (i = 0; i < 8; i++)
                r.base_name[8*i +: 8] = model_entry[i];
            for (i = 0; i < 3; i++)
                r.extension[8*i +: 8] = model_entry[8 + i];
            clus  = {model_entry[21], model_entry[20], model_entry[27], model_entry[26]};
            size  = {model_entry[31], model_entry[30], model_entry[29], model_entry[28]};
            bpc   = 24'(cfg_spc) * 24'(cfg_bps);
            count = '0;
            if (r.entry_kind == KIND_FILE && size != 32'd0)
            begin
                if (bpc == 24'd0)
                    count = 64'hFFFF_FFFF;
                else
                    count = (64'(size) + 64'(bpc) - 64'd1) / 64'(bpc);
            end
            rel = clus - 32'd2;   // wraps below cluster 2
            r.attributes    = model_entry[11];
            r.first_cluster = clus;
            r.file_size     = size;
            r.cluster_count = count[31:0];
            r.first_sector  = cfg_part_start + cfg_data_start + 48'(rel) * 48'(cfg_spc);
        end
        return r;
    endfunction

    // Advance the decoder copy by one accepted byte
    task automatic take_byte(logic [7:0] data, logic last);
        result_t r;
        if (model_skip)
        begin
            if (last)
            begin
                model_skip = 1'b0;
                model_pos  = '0;
            end
        end
        else
        begin
            model_entry[model_pos] = data;
            if (model_pos == LAST_POS)
            begin
                r = decode_entry();
                decoded_entries.push_back(r);
                model_pos = '0;
                if (r.entry_kind == KIND_END && !last)
                    model_skip = 1'b1;
            end
            else
                model_pos = model_pos + 5'd1;
            if (last)
                model_pos = '0;
        end
    endtask

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    task automatic check_entry(result_t got);
        result_t want;
        if (decoded_entries.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: entry expected none, got kind %0d", $time, got.entry_kind);
        end
        else
        begin
            want = decoded_entries.pop_front();
            compare_field("entry_kind", 64'(want.entry_kind), 64'(got.entry_kind));
            compare_field("base_name", want.base_name, got.base_name);
            compare_field("extension", 64'(want.extension), 64'(got.extension));
            compare_field("attributes", 64'(want.attributes), 64'(got.attributes));
            compare_field("first_cluster", 64'(want.first_cluster), 64'(got.first_cluster));
            compare_field("file_size", 64'(want.file_size), 64'(got.file_size));
            compare_field("cluster_count", 64'(want.cluster_count), 64'(got.cluster_count));
            compare_field("first_sector", 64'(want.first_sector), 64'(got.first_sector));
            kind_seen[want.entry_kind]++;
            entries_seen++;
        end
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        byte_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (byte_taken)
            take_byte(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_entry(result_t'(m_axis_tdata[RESULT_BITS-1:0]));
        if (byte_taken || (rst_n && m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
    end

    // Byte driver: next item or an idle burst after each accepted item
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || byte_taken))
        begin
            next_valid = 1'b0;
            if (tx_gap > 0)
                tx_gap--;
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                tx_gap = $urandom_range(2);
            else if (pending_bytes.size() != 0)
            begin
                sent = pending_bytes.pop_front();
                s_axis_tdata <= sent.data;
                s_axis_tlast <= sent.last;
                next_valid = 1'b1;
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Result receiver: idle bursts and one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            next_ready = 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            next_ready = 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            rx_gap = $urandom_range(2);
            next_ready = 1'b0;
        end
        else
            next_ready = 1'b1;
        m_axis_tready <= next_ready;
    end

    // Watchdog on a stalled stream
    initial
    begin
        wait (rst_n);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("fat_directory_entry_decoder: mismatch");
        $finish;
    end

    task automatic push_byte(logic [7:0] data, logic last);
        stream_byte_t item;
        item.data = data;
        item.last = last;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    // First n bytes of an entry, the last of them optionally ending the cluster
    task automatic push_entry(logic [255:0] e, int n, logic ends_cluster);
        int i;
        for (i = 0; i < n; i++)
            push_byte(e[8*i +: 8], ends_cluster && i == n - 1);
    endtask

    function automatic logic [255:0] make_entry(logic [7:0] lead, logic [7:0] attr,
                                                logic [31:0] clus, logic [31:0] size);
        logic [255:0] e;
        int i;
        for (i = 0; i < 8; i++)
            e[32*i +: 32] = $urandom;
        e[7:0]        = lead;
        e[8*11 +: 8]  = attr;
        e[8*20 +: 16] = clus[31:16];
        e[8*26 +: 16] = clus[15:0];
        e[8*28 +: 32] = size;
        return e;
    endfunction

    // Well-formed entry of a random kind, sizes biased towards the division edges
    function automatic logic [255:0] random_entry();
        logic [7:0]  lead;
        logic [7:0]  attr;
        logic [31:0] clus;
        logic [31:0] size;
        logic [31:0] bpc;
        int pick;
        lead = 8'($urandom);
        attr = 8'($urandom);
        if (lead == LEAD_END || lead == LEAD_DELETED)
            lead = 8'h41;
        pick = $urandom_range(99);
        if (pick < 8)
            lead = LEAD_END;
        else if (pick < 18)
            lead = LEAD_DELETED;
        else if (pick < 28)
            attr = ATTR_LONG_NAME;
        else if (pick < 45)
            attr = attr | ATTR_DIR_MASK;
        else if (pick < 90)
        begin
            attr = attr & ~ATTR_DIR_MASK;
            if (attr == ATTR_LONG_NAME)
                attr = 8'h20;
        end
        else
            lead = 8'($urandom);
        case ($urandom_range(7))
            0: clus = 32'd0;
            1: clus = 32'd1;
            2: clus = 32'd2;
            3: clus = 32'hFFFF_FFFF;
            default: clus = $urandom;
        endcase
        bpc = 32'(cfg_spc) * 32'(cfg_bps);
        case ($urandom_range(7))
            0: size = 32'd0;
            1: size = 32'hFFFF_FFFF;
            2: size = bpc * 32'($urandom_range(1, 5));
            3: size = bpc * 32'($urandom_range(1, 5)) + 32'd1;
            4: size = bpc - 32'd1 + 32'(bpc == 32'd1);
            5: size = 32'($urandom_range(1, 1000));
            default: size = $urandom;
        endcase
        return make_entry(lead, attr, clus, size);
    endfunction

    // One cluster: one to four entries, maybe an end marker part way, maybe a partial tail; or raw noise
    task automatic queue_random_cluster();
        int n;
        int tail;
        int end_at;
        int i;
        logic [255:0] e;
        if ($urandom_range(9) == 0)
        begin
            // noise: raw bytes of random length up to 70
            n = $urandom_range(1, 70);
            for (i = 0; i < n; i++)
                push_byte(8'($urandom), i == n - 1);
        end
        else
        begin
            n      = $urandom_range(1, 4);
            end_at = ($urandom_range(4) == 0) ? $urandom_range(n - 1) : -1;
            tail   = ($urandom_range(2) == 0) ? $urandom_range(1, 31) : 0;
            for (i = 0; i < n; i++)
            begin
                e = random_entry();
                if (i == end_at)
                    e[7:0] = LEAD_END;
                push_entry(e, 32, tail == 0 && i == n - 1);
            end
            if (tail != 0)
                push_entry(random_entry(), tail, 1'b1);
        end
    endtask

    // Register writes on back-to-back cycles, block idle
    task automatic write_config(logic [47:0] ps, logic [47:0] drs,
                                logic [7:0] spc, logic [15:0] bps);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PARTITION_START;
        cfg_wdata <= ps;
        @(negedge clk);
        cfg_index <= CFG_DATA_REGION_START;
        cfg_wdata <= drs;
        @(negedge clk);
        cfg_index <= CFG_CLUSTER_SECTORS;
        cfg_wdata <= 48'(spc);
        @(negedge clk);
        cfg_index <= CFG_SECTOR_BYTES;
        cfg_wdata <= 48'(bps);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_part_start = ps;
        cfg_data_start = drs;
        cfg_spc        = spc;
        cfg_bps        = bps;
        @(posedge clk);
    endtask

    // Wait until every byte is in and every entry is out, then let the back end settle
    task automatic drain();
        @(posedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || decoded_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [47:0] ps, logic [47:0] drs, logic [7:0] spc,
                             logic [15:0] bps, int budget, int idle, bit squeeze);
        int start;
        write_config(ps, drs, spc, bps);
        idle_pct = idle;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            queue_random_cluster();
        if (squeeze)
        begin
            @(posedge clk);
            hold_req = 1'b1;
        end
        drain();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed entries at the reset settings
        idle_pct = 20;
        push_entry(make_entry(8'h01, 8'h00, 32'd2, 32'hFFFF_FFFF), 32, 1'b0);
        push_entry({256{1'b1}}, 32, 1'b0);                        // directory, all bytes high
        push_entry(make_entry(LEAD_DELETED, 8'h20, $urandom, $urandom), 32, 1'b0);
        push_entry(make_entry(8'h41, ATTR_LONG_NAME, $urandom, $urandom), 32, 1'b0);
        push_entry(make_entry(8'h42, 8'h20, 32'd0, 32'd0), 32, 1'b0); // empty file, cluster wraps
        push_entry(make_entry(8'h05, 8'h01, 32'd1, 32'd1), 32, 1'b0);
        push_entry(make_entry(8'h46, 8'h00, 32'hFFFF_FFFF, 32'd512), 32, 1'b0);
        // end marker part way: rest of the cluster is skipped
        push_entry(make_entry(LEAD_END, 8'h00, $urandom, $urandom), 32, 1'b0);
        push_entry(random_entry(), 32, 1'b0);
        push_entry(random_entry(), 3, 1'b1);
        // partial entry dropped at cluster end
        push_entry(make_entry(8'h47, 8'h00, 32'd3, 32'd513), 32, 1'b0);
        push_entry(random_entry(), 5, 1'b1);
        // end marker on the cluster's last byte does not start skipping
        push_entry(make_entry(LEAD_END, 8'h00, $urandom, $urandom), 32, 1'b1);
        push_entry(make_entry(8'h48, 8'h10, 32'd5, 32'd0), 32, 1'b0);
        push_entry({248'd0, 8'h01}, 32, 1'b0);                    // file, all other bytes low
        push_byte(8'h00, 1'b1);                                   // one-byte cluster
        drain();

        // Random clusters over several register settings
        run_phase(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd255, 16'hFFFF, 150, 25, 1'b0);
        run_phase(48'd0, 48'd0, 8'd1, 16'd1, 150, 0, 1'b0);
        run_phase(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)), 220, 30, 1'b1);
        run_phase(48'($urandom), 48'($urandom), 8'(1 << $urandom_range(7)),
                  ($urandom_range(1) == 0) ? 16'd512 : 16'd4096, 150, 15, 1'b0);
        run_phase(48'({$urandom, $urandom}), 48'($urandom_range(32, 8192)), 8'd8, 16'd512,
                  150, 0, 1'b0);

        $display("Streamed %0d bytes; decoded %0d entries: %0d files, %0d directories,",
                 bytes_queued, entries_seen, kind_seen[KIND_FILE], kind_seen[KIND_DIR]);
        $display("%0d deleted, %0d long names, %0d end markers over six register settings",
                 kind_seen[KIND_DELETED], kind_seen[KIND_LONG_NAME], kind_seen[KIND_END]);
        if (mismatches == 0)
            $display("fat_directory_entry_decoder: match");
        else
            $display("fat_directory_entry_decoder: mismatch");
        $finish;
    end

endmodule
